/* hdl/bfa_pkg.sv */
// Shared types and constants for the bitmap frame allocator.
// Used by bfa_word_unit and bitmap_frame_allocator_core; depends on nothing.
package bfa_pkg;

	// Field widths of the stream items and the configuration register.
	localparam int OP_W    = 2;
	localparam int FRAME_W = 10;
	localparam int STAT_W  = 2;
	localparam int CFG_W   = 11;
	localparam int COUNT_W = 11;

	// Packed stream widths, filled up to whole bytes.
	localparam int S_DATA_W = 16;
	localparam int M_DATA_W = 24;

	// Free map word geometry: one memory row holds WORD_W frame bits.
	localparam int WORD_W = 32;
	localparam int BIT_W  = 5;
	localparam int LIM_W  = 6;

	// Frames in use after reset.
	localparam int CFG_RESET = 1024;

	typedef logic [OP_W-1:0]   op_t;
	typedef logic [STAT_W-1:0] status_t;

	// Request codes.
	localparam op_t OP_ALLOC = 2'd0;
	localparam op_t OP_FREE  = 2'd1;
	localparam op_t OP_INIT  = 2'd2;
	localparam op_t OP_NOP   = 2'd3;

	// Result status codes.
	localparam status_t ST_OK      = 2'd0;
	localparam status_t ST_NO_FREE = 2'd1;
	localparam status_t ST_ALREADY = 2'd2;
	localparam status_t ST_INVALID = 2'd3;

	// Results of the shared word unit for one free map row.
	typedef struct packed {
		logic              found;
		logic [BIT_W-1:0]  low_bit;
		logic [WORD_W-1:0] alloc_word;
		logic              sel_bit;
		logic [WORD_W-1:0] free_word;
	} wu_res_t;

endpackage

/* hdl/bfa_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Holds the free map rows; depends on nothing.
module bfa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* hdl/bfa_word_unit.sv */
// Shared word unit: masks one free map row to the frames in use, finds the
// lowest free bit, and tests or sets a selected bit. Depends on bfa_pkg.
module bfa_word_unit (
	input  logic [bfa_pkg::WORD_W-1:0] word,
	input  logic [bfa_pkg::LIM_W-1:0]  limit,
	input  logic [bfa_pkg::BIT_W-1:0]  bit_sel,
	output bfa_pkg::wu_res_t           res
);

	logic [bfa_pkg::WORD_W-1:0] in_use_mask;
	logic [bfa_pkg::WORD_W-1:0] masked;
	logic [bfa_pkg::WORD_W-1:0] lowest;
	logic [bfa_pkg::WORD_W-1:0] sel_onehot;
	logic [bfa_pkg::BIT_W-1:0]  enc;

	// Only bit positions below the limit belong to frames in use.
	always_comb begin
		for (int b = 0; b < bfa_pkg::WORD_W; b++) begin
			in_use_mask[b] = (bfa_pkg::LIM_W'(b) < limit);
		end
	end

	assign masked = word & in_use_mask;

	// Isolate the lowest set bit, then encode the one-hot position.
	assign lowest = masked & (~masked + bfa_pkg::WORD_W'(1));

	always_comb begin
		enc = '0;
		for (int b = 0; b < bfa_pkg::WORD_W; b++) begin
			if (lowest[b]) begin
				enc = enc | bfa_pkg::BIT_W'(b);
			end
		end
	end

	assign sel_onehot = bfa_pkg::WORD_W'(1) << bit_sel;

	always_comb begin
		res.found      = |masked;
		res.low_bit    = enc;
		res.alloc_word = word & ~lowest;
		res.sel_bit    = word[bit_sel];
		res.free_word  = word | sel_onehot;
	end

endmodule

/* hdl/bitmap_frame_allocator_core.sv */
// Top level of the bitmap first-fit frame allocator: request sequencer,
// free counter and output register. Depends on bfa_pkg, bfa_ram, bfa_word_unit.
//
//  Channel  Dir  Handshake            Contents
//  s_*      in   s_tvalid/s_tready    operation, frame_index
//  m_*      out  m_tvalid/m_tready    status, frame, free_count
//  cfg_*    in   cfg_we               frames_in_use
//
// One request at a time. Allocate checks the free map rows from row 0 until it
// finds a free frame or passes the last row; the single memory read port paces
// the scan. A valid free checks its one row; initialize, no-op and allocate
// with no free frame go straight to the result. Reset clears the row valid bits
// at once, so every frame reads as free with no clearing pass. A result waiting
// on m_tready holds the next request only once it is finished.
// The input is not ready in a cycle that writes the configuration register.
module bitmap_frame_allocator_core #(
	parameter int MAX_FRAMES = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [bfa_pkg::CFG_W-1:0]     cfg_wdata,  // frames_in_use
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [bfa_pkg::S_DATA_W-1:0]  s_tdata,    // operation, frame_index
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [bfa_pkg::M_DATA_W-1:0]  m_tdata     // status, frame, free_count
);

	localparam int NUM_WORDS = (MAX_FRAMES + bfa_pkg::WORD_W - 1) / bfa_pkg::WORD_W;
	localparam int ROW_W     = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
	localparam int CMP_W     = ((ROW_W + bfa_pkg::BIT_W > bfa_pkg::CFG_W) ?
		(ROW_W + bfa_pkg::BIT_W) : bfa_pkg::CFG_W) + 1;
	localparam int RESET_FRAMES = (bfa_pkg::CFG_RESET > MAX_FRAMES) ?
		MAX_FRAMES : bfa_pkg::CFG_RESET;

	typedef enum logic [2:0] {
		IDLE,
		A_ISSUE,
		A_CHECK,
		F_ISSUE,
		F_CHECK,
		DONE
	} state_t;

	state_t                         state_q;
	logic [bfa_pkg::CFG_W-1:0]      cfg_q;
	logic [bfa_pkg::COUNT_W-1:0]    total_q;
	logic [NUM_WORDS-1:0]           valid_q;
	logic [ROW_W-1:0]               ptr_q;
	logic [bfa_pkg::BIT_W-1:0]      bit_sel_q;
	bfa_pkg::status_t               res_status_q;
	logic [bfa_pkg::FRAME_W-1:0]    res_frame_q;

	logic [bfa_pkg::CFG_W-1:0]      n_eff;
	bfa_pkg::op_t                   in_op;
	logic [bfa_pkg::FRAME_W-1:0]    in_idx;
	logic                           in_xfer;
	logic [CMP_W-1:0]               diff;
	logic                           last_row;
	logic [bfa_pkg::LIM_W-1:0]      limit;
	logic [ROW_W-1:0]               raddr;
	logic [bfa_pkg::WORD_W-1:0]     rdata;
	logic [bfa_pkg::WORD_W-1:0]     row_word;
	logic                           ram_we;
	logic [bfa_pkg::WORD_W-1:0]     ram_wdata;
	bfa_pkg::wu_res_t               wu;

	// Effective frame count, saturated at the map size.
	function automatic logic [bfa_pkg::CFG_W-1:0] eff_count(
		input logic [bfa_pkg::CFG_W-1:0] v
	);
		logic [bfa_pkg::CFG_W-1:0] r;
		if (v > MAX_FRAMES) begin
			r = bfa_pkg::CFG_W'(MAX_FRAMES);
		end else begin
			r = v;
		end
		return r;
	endfunction

	assign n_eff    = eff_count(cfg_q);
	assign in_op    = s_tdata[bfa_pkg::OP_W-1:0];
	assign in_idx   = s_tdata[bfa_pkg::OP_W +: bfa_pkg::FRAME_W];
	assign s_tready = (state_q == IDLE) && !cfg_we;
	assign in_xfer  = s_tvalid & s_tready;

	// Frames in use from the current row on; the last row needs a partial mask.
	assign diff     = CMP_W'(n_eff) - CMP_W'({ptr_q, bfa_pkg::BIT_W'(0)});
	assign last_row = (diff <= CMP_W'(bfa_pkg::WORD_W));
	assign limit    = last_row ? diff[bfa_pkg::LIM_W-1:0] : bfa_pkg::LIM_W'(bfa_pkg::WORD_W);

	// Read the next row ahead while the current one is checked.
	assign raddr = (state_q == A_CHECK) ? ROW_W'(ptr_q + ROW_W'(1)) : ptr_q;

	// A row never written since reset, the last configuration write or the last initialize reads as all free.
	assign row_word = valid_q[ptr_q] ? rdata : '1;

	assign ram_we = ((state_q == A_CHECK) && wu.found) ||
		((state_q == F_CHECK) && !wu.sel_bit);
	assign ram_wdata = (state_q == A_CHECK) ? wu.alloc_word : wu.free_word;

	bfa_ram #(
		.WIDTH (bfa_pkg::WORD_W),
		.DEPTH (NUM_WORDS)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ptr_q),
		.wdata (ram_wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	bfa_word_unit u_word (
		.word    (row_word),
		.limit   (limit),
		.bit_sel (bit_sel_q),
		.res     (wu)
	);

	// Request sequencer, free counter, row valid bits and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= IDLE;
			cfg_q        <= bfa_pkg::CFG_W'(bfa_pkg::CFG_RESET);
			total_q      <= bfa_pkg::COUNT_W'(RESET_FRAMES);
			valid_q      <= '0;
			ptr_q        <= '0;
			bit_sel_q    <= '0;
			res_status_q <= bfa_pkg::ST_OK;
			res_frame_q  <= '0;
			m_tvalid     <= 1'b0;
			m_tdata      <= '0;
		end else begin
			// Output register drains here unless the finished state reloads it.
			if (m_tvalid && m_tready && (state_q != DONE)) begin
				m_tvalid <= 1'b0;
			end

			case (state_q)
				IDLE: begin
					if (cfg_we) begin
						cfg_q   <= cfg_wdata;
						valid_q <= '0;
						total_q <= bfa_pkg::COUNT_W'(eff_count(cfg_wdata));
					end else if (in_xfer) begin
						res_status_q <= bfa_pkg::ST_OK;
						res_frame_q  <= '0;
						case (in_op)
							bfa_pkg::OP_ALLOC: begin
								ptr_q <= '0;
								if (total_q == '0) begin
									res_status_q <= bfa_pkg::ST_NO_FREE;
									state_q      <= DONE;
								end else begin
									state_q <= A_ISSUE;
								end
							end
							bfa_pkg::OP_FREE: begin
								ptr_q     <= ROW_W'(in_idx >> bfa_pkg::BIT_W);
								bit_sel_q <= in_idx[bfa_pkg::BIT_W-1:0];
								if (bfa_pkg::CFG_W'(in_idx) >= n_eff) begin
									res_status_q <= bfa_pkg::ST_INVALID;
									state_q      <= DONE;
								end else begin
									state_q <= F_ISSUE;
								end
							end
							bfa_pkg::OP_INIT: begin
								valid_q <= '0;
								total_q <= bfa_pkg::COUNT_W'(n_eff);
								state_q <= DONE;
							end
							default: begin
								state_q <= DONE;
							end
						endcase
					end
				end
				A_ISSUE: begin
					state_q <= A_CHECK;
				end
				A_CHECK: begin
					if (wu.found) begin
						res_frame_q    <= bfa_pkg::FRAME_W'({ptr_q, wu.low_bit});
						valid_q[ptr_q] <= 1'b1;
						if (total_q != '0) begin
							total_q <= total_q - bfa_pkg::COUNT_W'(1);
						end
						state_q <= DONE;
					end else if (last_row) begin
						res_status_q <= bfa_pkg::ST_NO_FREE;
						state_q      <= DONE;
					end else begin
						ptr_q <= ptr_q + ROW_W'(1);
					end
				end
				F_ISSUE: begin
					state_q <= F_CHECK;
				end
				F_CHECK: begin
					if (wu.sel_bit) begin
						res_status_q <= bfa_pkg::ST_ALREADY;
					end else begin
						valid_q[ptr_q] <= 1'b1;
						if (total_q < bfa_pkg::COUNT_W'(n_eff)) begin
							total_q <= total_q + bfa_pkg::COUNT_W'(1);
						end
					end
					state_q <= DONE;
				end
				DONE: begin
					if (!m_tvalid || m_tready) begin
						m_tvalid <= 1'b1;
						m_tdata  <= {1'b0, total_q, res_frame_q, res_status_q};
						state_q  <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

endmodule
